/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file smpb_checker.sv.
// Clock and reset are taken from clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define SMPB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked in and out of reset.
`define SMPB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

/* hw/rtl/smpb_pkg.sv */
// Shared types and constants for the seam backtrack block.
// No dependencies.
package smpb_pkg;

  localparam int unsigned DimW    = 7;  // config register width
  localparam int unsigned RowW    = 6;  // seam_row width
  localparam int unsigned ColOutW = 6;  // seam_column width
  localparam int unsigned DataW   = 32; // cost_value width
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DimW-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] column;
    logic               done;
  } smpb_res_t;

endpackage

/* hw/rtl/smpb_cost_store.sv */
// Cost matrix store: one write port, one read port, registered read data.
// Depends on nothing.
module smpb_cost_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/smpb_out_reg.sv */
// One-entry output register between the walker and the result channel.
// Depends on smpb_pkg.
module smpb_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  smpb_pkg::smpb_res_t res_i,
  output logic               res_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output smpb_pkg::smpb_res_t out_o
);
  import smpb_pkg::*;

  logic      vld_q, vld_d;
  smpb_res_t res_q;

  assign res_ready_o = !vld_q || !out_stall_i;
  assign vld_d       = res_ready_o ? res_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = res_q;

endmodule

/* hw/rtl/smpb_walker.sv */
// Load sequencer, bottom-row scan and upward walk over the cost store.
// Depends on smpb_pkg; drives the ports of smpb_cost_store.
module smpb_walker #(
  parameter int unsigned MaxWidth  = 64,
  parameter int unsigned MaxHeight = 64,
  parameter int unsigned Depth     = 4096,
  parameter int unsigned AddrW     = 12,
  parameter int unsigned CostW     = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [smpb_pkg::DataW-1:0]  cost_value_i,
  input  logic                        final_cost_i,
  input  logic [smpb_pkg::DimW-1:0]   width_i,
  input  logic [smpb_pkg::DimW-1:0]   height_i,
  output logic                        wr_en_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic [CostW-1:0]            wr_data_o,
  output logic                        rd_en_o,
  output logic [AddrW-1:0]            rd_addr_o,
  input  logic [CostW-1:0]            rd_data_i,
  output logic                        res_valid_o,
  output smpb_pkg::smpb_res_t         res_o,
  input  logic                        res_ready_i
);
  import smpb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;

  localparam logic [10:0] MAXW = 11'(MaxWidth);
  localparam logic [10:0] MAXH = 11'(MaxHeight);
  localparam logic [AddrW-1:0] LAST_ADDR = AddrW'(Depth - 1);

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] load_q, load_d;
  logic [DimW-1:0]  w_q, w_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [DimW-1:0]  k_q, k_d;
  logic             rd_vld_q, rd_vld_d;
  logic [DimW-1:0]  rd_col_q, rd_col_d;
  logic [CostW-1:0] best_q, best_d;
  logic [DimW-1:0]  x_q, x_d;
  logic [1:0]       ph_q, ph_d;
  logic [CostW-1:0] up_q, up_d;
  logic [CostW-1:0] l_q, l_d;

  logic             in_xfer;
  logic [DimW-1:0]  wc, hc, hm1;
  logic             has_l, has_r;
  logic [AddrW-1:0] addr_up, addr_l, addr_r;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Clamp dimensions: zero counts as one, large values saturate.
  always_comb begin
    if (width_i == '0) begin
      wc = DimW'(1);
    end else if ({4'b0, width_i} > MAXW) begin
      wc = MAXW[DimW-1:0];
    end else begin
      wc = width_i;
    end
    if (height_i == '0) begin
      hc = DimW'(1);
    end else if ({4'b0, height_i} > MAXH) begin
      hc = MAXH[DimW-1:0];
    end else begin
      hc = height_i;
    end
  end
  assign hm1 = hc - DimW'(1);

  assign has_l   = (x_q != '0);
  assign has_r   = ((x_q + DimW'(1)) != w_q);
  assign addr_up = base_q + AddrW'(x_q);
  assign addr_l  = has_l ? addr_up - AddrW'(1) : addr_up;
  assign addr_r  = has_r ? addr_up + AddrW'(1) : addr_up;

  assign wr_en_o   = in_xfer;
  assign wr_addr_o = load_q;
  assign wr_data_o = cost_value_i[CostW-1:0];

  assign res_o.row    = row_q;
  assign res_o.column = x_q[ColOutW-1:0];
  assign res_o.done   = (row_q == '0);

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    w_d         = w_q;
    row_d       = row_q;
    base_d      = base_q;
    k_d         = k_q;
    rd_vld_d    = 1'b0;
    rd_col_d    = rd_col_q;
    best_d      = best_q;
    x_d         = x_q;
    ph_d        = ph_q;
    up_d        = up_q;
    l_d         = l_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = addr_up;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (final_cost_i) begin
            load_d  = '0;
            w_d     = wc;
            row_d   = hm1[RowW-1:0];
            base_d  = AddrW'(AddrW'(hm1) * AddrW'(wc));
            k_d     = '0;
            state_d = S_SCAN;
          end else if (load_q == LAST_ADDR) begin
            load_d = '0;
          end else begin
            load_d = load_q + AddrW'(1);
          end
        end
      end

      S_SCAN: begin
        // Leftmost minimum: only a strictly lower cost replaces the best.
        if (rd_vld_q && (rd_col_q == '0 || rd_data_i < best_q)) begin
          best_d = rd_data_i;
          x_d    = rd_col_q;
        end
        if (k_q != w_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = base_q + AddrW'(k_q);
          rd_vld_d  = 1'b1;
          rd_col_d  = k_q;
          k_d       = k_q + DimW'(1);
        end else if (!rd_vld_q) begin
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (row_q == '0) begin
            state_d = S_IDLE;
          end else begin
            row_d   = row_q - RowW'(1);
            base_d  = base_q - AddrW'(w_q);
            ph_d    = 2'd0;
            state_d = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        // Reads up, left, right on successive cycles from the store's registered read port.
        ph_d = ph_q + 2'd1;
        case (ph_q)
          2'd0: begin
            rd_en_o   = 1'b1;
            rd_addr_o = addr_up;
          end
          2'd1: begin
            up_d      = rd_data_i;
            rd_en_o   = 1'b1;
            rd_addr_o = addr_l;
          end
          2'd2: begin
            l_d       = rd_data_i;
            rd_en_o   = 1'b1;
            rd_addr_o = addr_r;
          end
          default: begin
            if (has_l && l_q < up_q && (!has_r || l_q <= rd_data_i)) begin
              x_d = x_q - DimW'(1);
            end else if (has_r && rd_data_i < up_q && (!has_l || rd_data_i <= l_q)) begin
              x_d = x_q + DimW'(1);
            end
            state_d = S_EMIT;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      load_q   <= '0;
      x_q      <= '0;
      best_q   <= '0;
      rd_vld_q <= 1'b0;
      k_q      <= '0;
      ph_q     <= '0;
      w_q      <= DIM_RESET;
      row_q    <= '0;
      base_q   <= '0;
    end else begin
      state_q  <= state_d;
      load_q   <= load_d;
      x_q      <= x_d;
      best_q   <= best_d;
      rd_vld_q <= rd_vld_d;
      k_q      <= k_d;
      ph_q     <= ph_d;
      w_q      <= w_d;
      row_q    <= row_d;
      base_q   <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q <= rd_col_d;
    up_q     <= up_d;
    l_q      <= l_d;
  end

endmodule

/* hw/rtl/seam_min_path_backtrack.sv */
// Top level of the seam backtrack block: config registers, cost store,
// walker and output register. Depends on smpb_pkg and the smpb_* modules.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o cost_value_i, final_cost_i
//  out      output     out_valid_o / out_stall_i seam_row_o, seam_column_o, seam_done_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A cost is taken every cycle while loading; each transfer is one store write.
// After the final cost the input stalls while the walker runs: a bottom-row scan
// over the single read port, then per row three reads, a decide step and emit.
// Output stalls simply hold the walker in its emit step.
// Reset clears control state only; the cost store has no clearing pass.
module seam_min_path_backtrack #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned COST_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [smpb_pkg::DataW-1:0]     cost_value_i,
  input  logic                           final_cost_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smpb_pkg::RowW-1:0]      seam_row_o,
  output logic [smpb_pkg::ColOutW-1:0]   seam_column_o,
  output logic                           seam_done_o,
  input  logic                           cfg_we_i,
  input  logic [smpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [smpb_pkg::DimW-1:0]      cfg_wdata_i
);
  import smpb_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CostW = (COST_BITS < DataW) ? COST_BITS : DataW;

  logic [DimW-1:0]  width_q, height_q;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [CostW-1:0] wr_data, rd_data;
  logic             res_valid, res_ready;
  smpb_res_t        res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  smpb_cost_store #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (CostW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  smpb_walker #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT),
    .Depth     (Depth),
    .AddrW     (AddrW),
    .CostW     (CostW)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cost_value_i (cost_value_i),
    .final_cost_i (final_cost_i),
    .width_i      (width_q),
    .height_i     (height_q),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  smpb_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign seam_row_o    = out_res.row;
  assign seam_column_o = out_res.column;
  assign seam_done_o   = out_res.done;

endmodule

/* hw/rtl/smpb_checker.sv */
// Port-level checks for seam_min_path_backtrack, bound to the top level.
// Depends on assert_macros.svh and smpb_pkg.
`include "assert_macros.svh"

module smpb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         final_cost_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [smpb_pkg::RowW-1:0]    seam_row_o,
  input logic [smpb_pkg::ColOutW-1:0] seam_column_o,
  input logic                         seam_done_o
);

  // A stalled result holds.
  `SMPB_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(seam_row_o) && $stable(seam_column_o) && $stable(seam_done_o))

  // The final cost starts the search, so the input stalls next cycle.
  `SMPB_ASSERT(a_final_stalls, in_valid_i && !in_stall_o && final_cost_i |=> in_stall_o)

  // While a seam is still open, no new cost is taken.
  `SMPB_ASSERT(a_open_seam_stalls, out_valid_o && !seam_done_o |-> in_stall_o)

  // Only the top row closes a seam.
  `SMPB_ASSERT(a_done_on_top, out_valid_o && seam_done_o |-> seam_row_o == '0)

  // An edge seen in reset clears the output valid flag by the next edge.
  `SMPB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind seam_min_path_backtrack smpb_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .final_cost_i  (final_cost_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .seam_row_o    (seam_row_o),
  .seam_column_o (seam_column_o),
  .seam_done_o   (seam_done_o)
);
